// ----- sv/gbl_pkg.sv -----
`timescale 1ns / 1ps

package gbl_pkg;

  localparam int MAX_RADIUS = 16;
  localparam int MAX_LINE = 4096;
  localparam int WIN_DEPTH = 2 * MAX_RADIUS + 1;

  localparam int RADIUS_W = 5;
  localparam int RAD_W = $clog2(MAX_RADIUS + 1);
  localparam int C_W = RAD_W + 1;
  localparam int LINE_W = $clog2(MAX_LINE) + 1;
  localparam int X_W = LINE_W + 1;
  localparam int IDX_W = $clog2(WIN_DEPTH);
  localparam int WIN_MEM = 1 << IDX_W;
  localparam int SAMPLE_W = 8;
  localparam int COEF_W = 16;
  localparam int TSUM_W = COEF_W + $clog2(WIN_DEPTH);
  localparam int ACC_W = SAMPLE_W + TSUM_W;
  localparam int QUOT_W = 8;
  localparam int BIT_W = $clog2(QUOT_W);
  localparam int CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RADIUS = 2'd0,
    REG_RENORM = 2'd1
  } cfg_reg_e;

  typedef logic [MAX_RADIUS:0][MAX_RADIUS:0][COEF_W-1:0] coef_rom_t;

  typedef struct packed {
    logic              shift;
    logic              acc_clr;
    logic              mac;
    logic              tap_valid;
    logic [IDX_W-1:0]  tap_idx;
    logic [RAD_W-1:0]  tap_cidx;
    logic [RAD_W-1:0]  rad;
    logic              load_direct;
    logic              div_init;
    logic              div_step;
    logic [BIT_W-1:0]  div_bit;
  } cmd_t;

  typedef struct packed {
    logic edge_seen;
  } sts_t;

  function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
    logic [63:0] q;
    logic [64:0] r;
    q = '0;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[63:0], n[i]};
      if (r >= {1'b0, d}) begin
        r = r - {1'b0, d};
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic logic [63:0] exp_q30(input logic [63:0] f);
    logic [63:0] term;
    logic [63:0] sum;
    term = 64'd1 << 30;
    sum = 64'd1 << 30;
    for (int n = 1; n <= 16; n++) begin
      term = udiv64((term * f) >> 30, 64'(n));
      sum = sum + term;
    end
    return sum;
  endfunction

  function automatic logic [63:0] negexp_q30(input logic [63:0] f);
    return udiv64(64'd1 << 60, exp_q30(f));
  endfunction

  function automatic coef_rom_t build_rom();
    coef_rom_t rom;
    logic [MAX_RADIUS:0][63:0] w;
    logic [63:0] e1;
    logic [63:0] den;
    logic [63:0] num;
    logic [63:0] q;
    logic [63:0] g;
    logic [63:0] v;
    logic [63:0] s;
    logic [63:0] k;
    rom = '0;
    w = '0;
    e1 = negexp_q30(64'd1 << 30);
    for (int r = 1; r <= MAX_RADIUS; r++) begin
      den = 64'(2 * r * r);
      for (int c = 0; c <= r; c++) begin
        num = 64'(9 * c * c);
        q = udiv64(num, den);
        g = udiv64((num - q * den) << 30, den);
        v = negexp_q30(g);
        for (int i = 0; i < int'(q); i++) begin
          v = (v * e1) >> 30;
        end
        w[c] = v;
      end
      s = w[0];
      for (int c = 1; c <= r; c++) begin
        s = s + 2 * w[c];
      end
      for (int c = 0; c <= r; c++) begin
        k = (s != 0) ? udiv64(w[c] * 65536 + (s >> 1), s) : 64'd0;
        rom[r][c] = (k > 64'd65535) ? 16'hFFFF : k[COEF_W-1:0];
      end
    end
    return rom;
  endfunction

  localparam coef_rom_t COEF_ROM = build_rom();

endpackage

// ----- sv/gbl_ctrl.sv -----
`timescale 1ns / 1ps

module gbl_ctrl import gbl_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                last_in_line,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                line_done,
  input  logic [RADIUS_W-1:0] radius,
  input  logic                renormalize_edges,
  output cmd_t                cmd,
  input  sts_t                sts
);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_SETUP = 7'b0000010,
    S_MAC   = 7'b0000100,
    S_TAIL  = 7'b0001000,
    S_FIN   = 7'b0010000,
    S_DIV   = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_t;

  state_t                  state, state_next;
  logic [LINE_W-1:0]       line_pos, line_pos_next;
  logic [LINE_W-1:0]       p_cur, p_cur_next;
  logic [RAD_W-1:0]        r_cur, r_cur_next;
  logic                    last_cur, last_cur_next;
  logic signed [X_W-1:0]   x, x_next;
  logic signed [X_W-1:0]   final_x, final_x_next;
  logic signed [C_W-1:0]   c, c_next;
  logic [BIT_W-1:0]        div_cnt, div_cnt_next;

  logic [RAD_W-1:0]        eff_r;
  logic                    last_now;
  logic                    has_full;
  logic signed [X_W-1:0]   first_x;
  logic signed [X_W-1:0]   p_s;
  logic signed [C_W-1:0]   r_s;
  logic signed [X_W:0]     pos;
  logic signed [X_W:0]     idx_full;
  logic signed [C_W-1:0]   c_abs;

  always_comb begin
    if (radius == '0) begin
      eff_r = RAD_W'(1);
    end else if (radius > RADIUS_W'(MAX_RADIUS)) begin
      eff_r = RAD_W'(MAX_RADIUS);
    end else begin
      eff_r = radius[RAD_W-1:0];
    end
  end

  assign last_now = last_in_line || (line_pos == LINE_W'(MAX_LINE - 1));
  assign p_s = $signed({1'b0, p_cur});
  assign r_s = $signed({1'b0, r_cur});
  assign has_full = p_cur >= LINE_W'(r_cur);
  assign first_x = has_full ? $signed({1'b0, p_cur - LINE_W'(r_cur)}) : '0;
  assign pos = (X_W + 1)'(x) + (X_W + 1)'(c);
  assign idx_full = (X_W + 1)'(p_s) - pos;
  assign c_abs = (c < 0) ? -c : c;

  assign in_ready = (state == S_IDLE);
  assign out_valid = (state == S_OUT);
  assign line_done = (state == S_OUT) && last_cur && (x == final_x);

  always_comb begin
    state_next = state;
    line_pos_next = line_pos;
    p_cur_next = p_cur;
    r_cur_next = r_cur;
    last_cur_next = last_cur;
    x_next = x;
    final_x_next = final_x;
    c_next = c;
    div_cnt_next = div_cnt;
    cmd = '0;
    cmd.rad = r_cur;
    cmd.tap_valid = (pos >= 0) && (pos <= (X_W + 1)'(p_s));
    cmd.tap_idx = idx_full[IDX_W-1:0];
    cmd.tap_cidx = c_abs[RAD_W-1:0];
    cmd.div_bit = div_cnt;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.shift = 1'b1;
          p_cur_next = line_pos;
          r_cur_next = eff_r;
          last_cur_next = last_now;
          line_pos_next = last_now ? '0 : line_pos + LINE_W'(1);
          state_next = S_SETUP;
        end
      end
      S_SETUP: begin
        if (!has_full && !last_cur) begin
          state_next = S_IDLE;
        end else begin
          x_next = first_x;
          final_x_next = last_cur ? p_s : first_x;
          c_next = -r_s;
          cmd.acc_clr = 1'b1;
          state_next = S_MAC;
        end
      end
      S_MAC: begin
        cmd.mac = 1'b1;
        if (c == r_s) begin
          state_next = S_TAIL;
        end else begin
          c_next = c + C_W'(1);
        end
      end
      S_TAIL: begin
        state_next = S_FIN;
      end
      S_FIN: begin
        if (sts.edge_seen && renormalize_edges) begin
          cmd.div_init = 1'b1;
          div_cnt_next = BIT_W'(QUOT_W - 1);
          state_next = S_DIV;
        end else begin
          cmd.load_direct = 1'b1;
          state_next = S_OUT;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (div_cnt == '0) begin
          state_next = S_OUT;
        end else begin
          div_cnt_next = div_cnt - BIT_W'(1);
        end
      end
      S_OUT: begin
        if (out_ready) begin
          if (x == final_x) begin
            state_next = S_IDLE;
          end else begin
            x_next = x + X_W'(1);
            c_next = -r_s;
            cmd.acc_clr = 1'b1;
            state_next = S_MAC;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      line_pos <= '0;
      p_cur <= '0;
      r_cur <= RAD_W'(1);
      last_cur <= 1'b0;
      x <= '0;
      final_x <= '0;
      c <= '0;
      div_cnt <= '0;
    end else begin
      state <= state_next;
      line_pos <= line_pos_next;
      p_cur <= p_cur_next;
      r_cur <= r_cur_next;
      last_cur <= last_cur_next;
      x <= x_next;
      final_x <= final_x_next;
      c <= c_next;
      div_cnt <= div_cnt_next;
    end
  end

endmodule

// ----- sv/gbl_datapath.sv -----
`timescale 1ns / 1ps

module gbl_datapath import gbl_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic [SAMPLE_W-1:0] sample,
  input  cmd_t                cmd,
  output sts_t                sts,
  output logic [SAMPLE_W-1:0] blurred
);

  logic [SAMPLE_W-1:0]         win [WIN_MEM];
  logic [IDX_W-1:0]            wr_ptr;
  logic [SAMPLE_W-1:0]         rd_data;
  logic [COEF_W-1:0]           coef_q;
  logic                        mac_q;
  logic                        valid_q;
  logic [ACC_W-1:0]            acc;
  logic [TSUM_W-1:0]           tsum;
  logic                        edge_seen;
  logic [ACC_W-1:0]            rem;
  logic [QUOT_W-1:0]           quot;
  logic                        zero_f;
  logic                        sat_f;
  logic [SAMPLE_W-1:0]         result;

  logic [IDX_W-1:0]            rd_addr;
  logic [COEF_W-1:0]           coef;
  logic [SAMPLE_W+COEF_W-1:0]  prod;
  logic [ACC_W-1:0]            tsh;
  logic                        take;
  logic [QUOT_W-1:0]           quot_n;
  logic [ACC_W-17:0]           direct;

  // The window is a circular buffer; age 0 is the newest sample.
  assign rd_addr = wr_ptr - IDX_W'(1) - cmd.tap_idx;
  assign coef = COEF_ROM[cmd.rad][cmd.tap_cidx];
  assign prod = (SAMPLE_W + COEF_W)'(rd_data) * (SAMPLE_W + COEF_W)'(coef_q);
  assign tsh = ACC_W'(tsum) << cmd.div_bit;
  assign take = rem >= tsh;
  always_comb begin
    quot_n = quot;
    quot_n[cmd.div_bit] = take;
  end
  assign direct = acc[ACC_W-1:16];

  assign sts.edge_seen = edge_seen;
  assign blurred = result;

  always_ff @(posedge clk) begin
    if (cmd.shift) begin
      win[wr_ptr] <= sample;
    end
    rd_data <= win[rd_addr];
    coef_q <= coef;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      mac_q <= 1'b0;
      valid_q <= 1'b0;
      edge_seen <= 1'b0;
    end else begin
      if (cmd.shift) begin
        wr_ptr <= wr_ptr + IDX_W'(1);
      end
      mac_q <= cmd.mac;
      valid_q <= cmd.tap_valid;
      if (cmd.acc_clr) begin
        edge_seen <= 1'b0;
      end else if (mac_q && !valid_q) begin
        edge_seen <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.acc_clr) begin
      acc <= '0;
      tsum <= '0;
    end else if (mac_q && valid_q) begin
      acc <= acc + ACC_W'(prod);
      tsum <= tsum + TSUM_W'(coef_q);
    end
    if (cmd.div_init) begin
      rem <= acc;
      quot <= '0;
      zero_f <= (tsum == '0);
      sat_f <= acc >= {tsum, 8'b0};
    end else if (cmd.div_step) begin
      if (take) begin
        rem <= rem - tsh;
      end
      quot <= quot_n;
    end
    if (cmd.load_direct) begin
      result <= (direct > (ACC_W - 16)'(255)) ? 8'hFF : direct[SAMPLE_W-1:0];
    end else if (cmd.div_step && cmd.div_bit == '0) begin
      result <= zero_f ? 8'h00 : (sat_f ? 8'hFF : quot_n);
    end
  end

endmodule

// ----- sv/gaussian_blur_line.sv -----
`timescale 1ns / 1ps

// Channel  Direction  Handshake            Payload
// in       input      in_valid/in_ready    sample, last_in_line
// out      output     out_valid/out_ready  blurred, line_done
// cfg      input      cfg_valid/cfg_ready  cfg_index, cfg_data
//
// An input is taken in S_IDLE and checked in S_SETUP. Each result then passes
// S_MAC (one tap multiply-accumulate per cycle behind a registered window read),
// S_TAIL, S_FIN, S_DIV for a renormalized edge only, and S_OUT.
// The tap loop runs through the single multiplier.
// Reset is synchronous and clears control state; the sample window is not cleared.
// A stalled output holds the block; the next input is taken once all results left.

module gaussian_blur_line import gbl_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [SAMPLE_W-1:0]  sample,
  input  logic                 last_in_line,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [SAMPLE_W-1:0]  blurred,
  output logic                 line_done,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [RADIUS_W-1:0]  cfg_data
);

  logic [RADIUS_W-1:0] radius;
  logic                renormalize_edges;
  cmd_t                cmd;
  sts_t                sts;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      radius <= RADIUS_W'(1);
      renormalize_edges <= 1'b1;
    end else if (cfg_valid) begin
      if (cfg_index == REG_RADIUS) begin
        radius <= cfg_data;
      end else if (cfg_index == REG_RENORM) begin
        renormalize_edges <= cfg_data[0];
      end
    end
  end

  gbl_ctrl u_ctrl (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .last_in_line      (last_in_line),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .line_done         (line_done),
    .radius            (radius),
    .renormalize_edges (renormalize_edges),
    .cmd               (cmd),
    .sts               (sts)
  );

  gbl_datapath u_datapath (
    .clk     (clk),
    .rst     (rst),
    .sample  (sample),
    .cmd     (cmd),
    .sts     (sts),
    .blurred (blurred)
  );

`ifndef ASSERT_OFF
  a_busy_excl: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("input ready while a result is pending");

  a_busy_after_in: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("block ready right after an input transaction");

  a_idle_after_done: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && line_done |=> in_ready && !out_valid)
    else $error("block not idle after the last result of a line");
`endif

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
  import gbl_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_HI = 2'd3;
  localparam int CYCLE_LIMIT = 3000000;
  localparam int DRAIN_CYCLES = 2 * (2 * MAX_RADIUS + 4 + 8) + 20;

  typedef struct {
    logic [SAMPLE_W-1:0] value;
    logic                last;
  } sample_item_t;

  typedef struct {
    logic [SAMPLE_W-1:0] blurred;
    logic                line_done;
  } blur_result_t;

  logic clk;
  logic rst;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [SAMPLE_W-1:0] sample = '0;
  logic last_in_line = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [SAMPLE_W-1:0] blurred;
  logic line_done;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [RADIUS_W-1:0] cfg_data;

  sample_item_t pending_samples[$];
  blur_result_t expected_blur[$];
  bit [63:0] kernel[MAX_RADIUS+1][MAX_RADIUS+1];
  logic [SAMPLE_W-1:0] line_window[WIN_DEPTH] = '{default: '0};
  int line_pos = 0;
  logic [RADIUS_W-1:0] radius_reg = RADIUS_W'(1);
  logic renorm_reg = 1'b1;
  int sender_idle_pct;
  int receiver_idle_pct;
  int errors = 0;
  int cycles = 0;
  logic in_taken = 1'b0;

  gaussian_blur_line dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .sample(sample), .last_in_line(last_in_line),
    .out_valid(out_valid), .out_ready(out_ready),
    .blurred(blurred), .line_done(line_done),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic bit [63:0] exp_fixed(bit [63:0] f);
    bit [63:0] term;
    bit [63:0] sum;
    term = 64'd1 << 30;
    sum = term;
    for (int n = 1; n <= 16; n++) begin
      term = ((term * f) >> 30) / n;
      sum += term;
    end
    return sum;
  endfunction

  function automatic bit [63:0] recip_exp(bit [63:0] f);
    return (64'd1 << 60) / exp_fixed(f);
  endfunction

  function automatic void make_kernels();
    bit [63:0] e1;
    bit [63:0] w[MAX_RADIUS+1];
    bit [63:0] den;
    bit [63:0] num;
    bit [63:0] q;
    bit [63:0] v;
    bit [63:0] s;
    bit [63:0] k;
    e1 = recip_exp(64'd1 << 30);
    for (int r = 0; r <= MAX_RADIUS; r++)
      for (int c = 0; c <= MAX_RADIUS; c++) kernel[r][c] = 0;
    for (int r = 1; r <= MAX_RADIUS; r++) begin
      den = 64'(2 * r * r);
      for (int c = 0; c <= r; c++) begin
        num = 64'(9 * c * c);
        q = num / den;
        v = recip_exp(((num % den) << 30) / den);
        for (int i = 0; i < int'(q); i++) v = (v * e1) >> 30;
        w[c] = v;
      end
      s = w[0];
      for (int c = 1; c <= r; c++) s += 2 * w[c];
      for (int c = 0; c <= r; c++) begin
        k = (s != 0) ? (w[c] * 65536 + s / 2) / s : 0;
        kernel[r][c] = (k > 65535) ? 64'd65535 : k;
      end
    end
  endfunction

  function automatic logic [SAMPLE_W-1:0] blur_value(int x, int p, int r);
    bit [63:0] acc;
    bit [63:0] tsum;
    bit [63:0] res;
    bit at_edge;
    int pos;
    acc = 0;
    tsum = 0;
    at_edge = 0;
    for (int c = -r; c <= r; c++) begin
      pos = x + c;
      if (pos < 0 || pos > p || p - pos >= WIN_DEPTH) begin
        at_edge = 1;
      end else begin
        acc += line_window[p - pos] * kernel[r][c < 0 ? -c : c];
        tsum += kernel[r][c < 0 ? -c : c];
      end
    end
    if (at_edge && renorm_reg) res = (tsum != 0) ? acc / tsum : 0;
    else res = acc >> 16;
    return (res > 255) ? 8'd255 : res[7:0];
  endfunction

  function automatic void predict_blur(sample_item_t item);
    int r;
    int p;
    int first_x;
    int final_x;
    bit ends;
    blur_result_t res;
    r = (radius_reg == 0) ? 1 : (radius_reg > MAX_RADIUS) ? MAX_RADIUS : radius_reg;
    p = line_pos;
    ends = item.last || (line_pos >= MAX_LINE - 1);
    for (int i = WIN_DEPTH - 1; i > 0; i--) line_window[i] = line_window[i-1];
    line_window[0] = item.value;
    first_x = ends ? ((p >= r) ? p - r : 0) : p - r;
    final_x = ends ? p : p - r;
    if (first_x >= 0) begin
      for (int x = first_x; x <= final_x; x++) begin
        res.blurred = blur_value(x, p, r);
        res.line_done = ends && (x == final_x);
        expected_blur.push_back(res);
      end
    end
    line_pos = ends ? 0 : line_pos + 1;
  endfunction

  always @(posedge clk) begin
    blur_result_t want;
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
    in_taken <= in_valid && in_ready;
    if (!rst) begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_RADIUS) radius_reg = cfg_data;
        else if (cfg_index == REG_RENORM) renorm_reg = cfg_data[0];
      end
      if (in_valid && in_ready) predict_blur('{sample, last_in_line});
      if (out_valid && out_ready) begin
        if (expected_blur.size() == 0) begin
          $display("%0t: unexpected transaction blurred=%0d line_done=%0d",
                   $time, blurred, line_done);
          errors++;
        end else begin
          want = expected_blur.pop_front();
          if (blurred !== want.blurred) begin
            $display("%0t: blurred expected %0d actual %0d", $time, want.blurred, blurred);
            errors++;
          end
          if (line_done !== want.line_done) begin
            $display("%0t: line_done expected %0d actual %0d",
                     $time, want.line_done, line_done);
            errors++;
          end
        end
      end
    end
  end

  always @(negedge clk) begin
    sample_item_t item;
    out_ready <= ($urandom_range(99) >= receiver_idle_pct);
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (pending_samples.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
        item = pending_samples.pop_front();
        in_valid <= 1'b1;
        sample <= item.value;
        last_in_line <= item.last;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [RADIUS_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic queue_line(int len, int kind, bit terminate);
    sample_item_t item;
    for (int i = 0; i < len; i++) begin
      case (kind)
        1: item.value = 8'd255;
        2: item.value = i[0] ? 8'd255 : 8'd0;
        default: item.value = SAMPLE_W'($urandom_range(255));
      endcase
      item.last = terminate && (i == len - 1);
      pending_samples.push_back(item);
    end
  endtask

  task automatic wait_idle();
    do @(posedge clk);
    while (pending_samples.size() != 0 || in_valid || expected_blur.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_config(logic [RADIUS_W-1:0] r, logic renorm);
    write_reg(REG_RADIUS, r);
    write_reg(REG_RENORM, RADIUS_W'(renorm));
  endtask

  initial begin
    int total;
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_index = REG_RADIUS;
    cfg_data = '0;
    sender_idle_pct = 8;
    receiver_idle_pct = 53;
    make_kernels();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    queue_line(1, 0, 1);
    queue_line(3, 2, 1);
    wait_idle();
    set_config(5'd16, 1'b0);
    queue_line(40, 1, 1);
    wait_idle();
    write_reg(REG_RENORM, 5'd1);
    queue_line(5, 2, 1);
    wait_idle();
    set_config(5'd0, 1'b0);
    write_reg(REG_UNUSED, 5'd31);
    write_reg(REG_UNUSED_HI, 5'd7);
    queue_line(4, 0, 1);
    wait_idle();
    set_config(5'd31, 1'b1);
    queue_line(6, 0, 1);
    wait_idle();

    for (int ph = 0; ph < 12; ph++) begin
      if (ph == 4) begin
        sender_idle_pct = 53;
        receiver_idle_pct = 8;
      end else if (ph == 8) begin
        sender_idle_pct = 0;
        receiver_idle_pct = 0;
      end
      set_config(RADIUS_W'(($urandom_range(3) == 0) ? $urandom_range(31)
                                                    : $urandom_range(1, 8)),
                 1'($urandom_range(1)));
      total = 0;
      while (total < 20) begin
        int len;
        len = ($urandom_range(5) == 0) ? 1 : $urandom_range(2, 40);
        queue_line(len, ($urandom_range(9) == 0) ? $urandom_range(1, 2) : 0, 1);
        total += len;
      end
      wait_idle();
    end

    if (errors == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
